FILE: rtl/dtc_pkg.sv
`default_nettype none
package dtc_pkg;

    // largest magnitude held in the coefficient store
    localparam logic [47:0] STORE_LIM = 48'h7FFF_FFFF_FFFF;

    // fixed point one in Q.16
    localparam logic signed [55:0] ONE_Q16 = 56'sd65536;

    // rounding shift applied by the multiplier
    typedef enum logic [1:0] {
        SH_16,
        SH_31,
        SH_32
    } shsel_t;

    typedef struct packed {
        logic               start;
        logic signed [55:0] a;
        logic signed [55:0] b;
        shsel_t             sh;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [47:0] value;
        logic               clip;
    } mul_rsp_t;

    // count of exponent triples below total order q
    function automatic logic [7:0] tetra(input logic [2:0] q);
        logic [7:0] t;
        begin
            case (q)
                3'd0:    t = 8'd0;
                3'd1:    t = 8'd1;
                3'd2:    t = 8'd4;
                3'd3:    t = 8'd10;
                3'd4:    t = 8'd20;
                3'd5:    t = 8'd35;
                3'd6:    t = 8'd56;
                default: t = 8'd84;
            endcase
            return t;
        end
    endfunction

    // store slot of exponent triple (l,m,n)
    function automatic logic [7:0] slot_of(input logic [2:0] l, input logic [2:0] m,
                                           input logic [2:0] n);
        logic [7:0] q;
        logic [7:0] tri_l;
        begin
            q     = 8'(l) + 8'(m) + 8'(n);
            tri_l = (8'(l) * (8'(l) - 8'd1)) >> 1;
            return tetra(q[2:0]) + 8'(l) * (q + 8'd1) - tri_l + 8'(m);
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/distance_taylor_coefficients.sv
`default_nettype none
// Sequence: squares, root, round, reciprocal, then per word a direct copy (order 0),
// one multiply (order 1), or one multiply per split product plus a final scaling
// multiply (order 2 and up), each on the shared four-pass multiplier.
// One point at a time; a zero-distance point skips the reciprocal and emits one word.
// Reset (rst_n, async low): control idle, max_order = 5, no word pending.
// Coefficient store needs no clearing; every slot is written before it is read.
module distance_taylor_coefficients #(
    parameter int MAX_ORDER  = 5,
    parameter int COEF_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // point input
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    // configuration write
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_data,
    // result words
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      coefficient,
    output logic [2:0]              power_x,
    output logic [2:0]              power_y,
    output logic [2:0]              power_z,
    output logic                    saturated,
    output logic                    zero_distance,
    output logic                    last_of_run
);

    // store depth: number of triples with total order up to MAX_ORDER
    localparam int STORE_DEPTH = (MAX_ORDER + 1) * (MAX_ORDER + 2) * (MAX_ORDER + 3) / 6;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    // emitted words clip to the narrower of COEF_WIDTH and the port
    localparam int EMIT_W      = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
    localparam logic signed [47:0] HI_LIM = 48'((64'd1 << (EMIT_W - 1)) - 64'd1);
    localparam logic signed [47:0] LO_LIM = -HI_LIM - 48'sd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_ROUND,
        S_DIV,
        S_COEF,
        S_RD,
        S_MSTART,
        S_MWAIT,
        S_EMIT
    } state_t;

    // what the multiplier is working on
    typedef enum logic [1:0] {
        PH_UNIT,
        PH_SPLIT,
        PH_FINAL
    } phase_t;

    state_t             state_reg;
    phase_t             phase_reg;
    logic [2:0]         max_order_reg;

    // point and distance
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [1:0]         sq_cnt_reg;
    logic [63:0]        sq_prod_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        root_s_reg;
    logic [63:0]        root_res_reg;
    logic [63:0]        root_bit_reg;
    logic [32:0]        dist_reg;
    logic               zero_reg;

    // reciprocal 1/(2r) in Q.48
    logic [47:0]        num_reg;
    logic [33:0]        rem_reg;
    logic [47:0]        inv_reg;
    logic [5:0]         div_cnt_reg;

    // coefficient sequencing
    logic [2:0]         q_reg, l_reg, m_reg;
    logic [2:0]         al_reg, am_reg, an_reg;
    logic signed [55:0] acc_reg;
    logic signed [47:0] v_reg;
    logic               f_reg;

    // output word register
    logic               out_valid_reg;
    logic signed [31:0] coef_reg;
    logic [2:0]         px_reg, py_reg, pz_reg;
    logic               sat_reg, zero_out_reg, last_reg;

    logic [2:0]         order;
    logic [2:0]         n_c;
    logic               last_c;
    logic               slot_free;
    logic [63:0]        sq_sel;
    logic [63:0]        root_try;
    logic [32:0]        dist_c;
    logic [33:0]        div_t;
    logic               div_ge;
    logic signed [55:0] unit_coord;
    logic signed [47:0] emit_v;
    logic               emit_clip;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [48:0]        ram_wdata, ram_rdata_a, ram_rdata_b;

    dtc_pkg::mul_req_t  mul_req;
    dtc_pkg::mul_rsp_t  mul_rsp;

    assign order   = (max_order_reg > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : max_order_reg;
    assign n_c     = q_reg - l_reg - m_reg;
    // final word of a point: highest order, all power on x
    assign last_c  = (q_reg == order) && (l_reg == q_reg);
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sq_sel = 64'(cx_reg) * 64'(cx_reg);
            2'd1:    sq_sel = 64'(cy_reg) * 64'(cy_reg);
            default: sq_sel = 64'(cz_reg) * 64'(cz_reg);
        endcase
    end

    assign root_try = root_res_reg + root_bit_reg;
    assign dist_c   = 33'(root_res_reg) + 33'(root_s_reg > root_res_reg);
    assign div_t    = {rem_reg[32:0], num_reg[47]};
    assign div_ge   = div_t >= {1'b0, dist_reg};

    always_comb
    begin
        if (l_reg != 3'd0)
        begin
            unit_coord = 56'(cx_reg);
        end
        else if (m_reg != 3'd0)
        begin
            unit_coord = 56'(cy_reg);
        end
        else
        begin
            unit_coord = 56'(cz_reg);
        end
    end

    // multiplier operands by phase
    always_comb
    begin
        mul_req.start = state_reg == S_MSTART;
        case (phase_reg)
            PH_SPLIT:
            begin
                mul_req.a  = 56'($signed(ram_rdata_a[47:0]));
                mul_req.b  = 56'($signed(ram_rdata_b[47:0]));
                mul_req.sh = dtc_pkg::SH_16;
            end
            PH_UNIT:
            begin
                mul_req.a  = unit_coord;
                mul_req.b  = $signed({8'd0, inv_reg});
                mul_req.sh = dtc_pkg::SH_31;
            end
            default:
            begin
                mul_req.a  = acc_reg;
                mul_req.b  = $signed({8'd0, inv_reg});
                mul_req.sh = dtc_pkg::SH_32;
            end
        endcase
    end

    // store: read both split factors, write the finished coefficient
    assign ram_raddr_a = ADDR_W'(dtc_pkg::slot_of(al_reg, am_reg, an_reg));
    assign ram_raddr_b = ADDR_W'(dtc_pkg::slot_of(l_reg - al_reg, m_reg - am_reg,
                                                  n_c - an_reg));
    assign ram_waddr   = ADDR_W'(dtc_pkg::slot_of(l_reg, m_reg, n_c));
    assign ram_wdata   = {f_reg, v_reg};
    assign ram_we      = (state_reg == S_EMIT) && slot_free && !zero_reg;

    assign emit_clip = (v_reg > HI_LIM) || (v_reg < LO_LIM);
    assign emit_v    = (v_reg > HI_LIM) ? HI_LIM : ((v_reg < LO_LIM) ? LO_LIM : v_reg);

    dtc_ram #(
        .WIDTH(49),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    dtc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_UNIT;
            max_order_reg <= 3'd5;
            out_valid_reg <= 1'b0;
            zero_reg      <= 1'b0;
            sq_cnt_reg    <= 2'd0;
            div_cnt_reg   <= 6'd0;
            q_reg         <= 3'd0;
            l_reg         <= 3'd0;
            m_reg         <= 3'd0;
            al_reg        <= 3'd0;
            am_reg        <= 3'd0;
            an_reg        <= 3'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_order_reg <= cfg_data;
            end

            // S_EMIT refills the slot itself when it frees
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cx_reg     <= coord_x;
                        cy_reg     <= coord_y;
                        cz_reg     <= coord_z;
                        sq_reg     <= 64'd0;
                        sq_cnt_reg <= 2'd0;
                        state_reg  <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    // square one coordinate a cycle, sum the previous one
                    sq_prod_reg <= sq_sel;
                    sq_cnt_reg  <= sq_cnt_reg + 2'd1;
                    if (sq_cnt_reg != 2'd0)
                    begin
                        sq_reg <= sq_reg + sq_prod_reg;
                    end
                    if (sq_cnt_reg == 2'd3)
                    begin
                        root_s_reg   <= sq_reg + sq_prod_reg;
                        root_res_reg <= 64'd0;
                        root_bit_reg <= 64'd1 << 62;
                        state_reg    <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    // one result bit per cycle
                    if (root_s_reg >= root_try)
                    begin
                        root_s_reg   <= root_s_reg - root_try;
                        root_res_reg <= (root_res_reg >> 1) + root_bit_reg;
                    end
                    else
                    begin
                        root_res_reg <= root_res_reg >> 1;
                    end
                    root_bit_reg <= root_bit_reg >> 2;
                    if (root_bit_reg == 64'd1)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    dist_reg <= dist_c;
                    if (dist_c == 33'd0)
                    begin
                        zero_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        zero_reg    <= 1'b0;
                        num_reg     <= (48'd1 << 47) + 48'(dist_c >> 1);
                        rem_reg     <= 34'd0;
                        div_cnt_reg <= 6'd0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    rem_reg     <= div_ge ? (div_t - {1'b0, dist_reg}) : div_t;
                    inv_reg     <= {inv_reg[46:0], div_ge};
                    num_reg     <= num_reg << 1;
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd47)
                    begin
                        q_reg     <= 3'd0;
                        l_reg     <= 3'd0;
                        m_reg     <= 3'd0;
                        state_reg <= S_COEF;
                    end
                end
                S_COEF:
                begin
                    f_reg <= 1'b0;
                    if (q_reg == 3'd0)
                    begin
                        v_reg     <= 48'(dist_reg);
                        state_reg <= S_EMIT;
                    end
                    else if (q_reg == 3'd1)
                    begin
                        phase_reg <= PH_UNIT;
                        state_reg <= S_MSTART;
                    end
                    else
                    begin
                        // delta term on pure second powers
                        if ((q_reg == 3'd2) &&
                            ((l_reg == q_reg) || (m_reg == q_reg) || (n_c == q_reg)))
                        begin
                            acc_reg <= dtc_pkg::ONE_Q16;
                        end
                        else
                        begin
                            acc_reg <= 56'sd0;
                        end
                        al_reg    <= 3'd0;
                        am_reg    <= 3'd0;
                        an_reg    <= 3'd0;
                        phase_reg <= PH_SPLIT;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if ((al_reg == l_reg) && (am_reg == m_reg) && (an_reg == n_c))
                    begin
                        // whole box walked; scale by 1/(2r)
                        phase_reg <= PH_FINAL;
                        state_reg <= S_MSTART;
                    end
                    else
                    begin
                        if (an_reg != n_c)
                        begin
                            an_reg <= an_reg + 3'd1;
                        end
                        else
                        begin
                            an_reg <= 3'd0;
                            if (am_reg != m_reg)
                            begin
                                am_reg <= am_reg + 3'd1;
                            end
                            else
                            begin
                                am_reg <= 3'd0;
                                al_reg <= al_reg + 3'd1;
                            end
                        end
                        // the empty split reads nothing
                        if ((al_reg != 3'd0) || (am_reg != 3'd0) || (an_reg != 3'd0))
                        begin
                            state_reg <= S_MSTART;
                        end
                    end
                end
                S_MSTART:
                begin
                    if (phase_reg == PH_SPLIT)
                    begin
                        f_reg <= f_reg | ram_rdata_a[48] | ram_rdata_b[48];
                    end
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        f_reg <= f_reg | mul_rsp.clip;
                        if (phase_reg == PH_SPLIT)
                        begin
                            acc_reg   <= acc_reg - 56'(mul_rsp.value);
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            v_reg     <= mul_rsp.value;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (zero_reg)
                        begin
                            coef_reg     <= 32'sd0;
                            px_reg       <= 3'd0;
                            py_reg       <= 3'd0;
                            pz_reg       <= 3'd0;
                            sat_reg      <= 1'b0;
                            zero_out_reg <= 1'b1;
                            last_reg     <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            coef_reg     <= emit_v[31:0];
                            px_reg       <= l_reg;
                            py_reg       <= m_reg;
                            pz_reg       <= n_c;
                            sat_reg      <= f_reg | emit_clip;
                            zero_out_reg <= 1'b0;
                            last_reg     <= last_c;
                            if (last_c)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                // next by ascending q, then l, then m
                                if (m_reg != (q_reg - l_reg))
                                begin
                                    m_reg <= m_reg + 3'd1;
                                end
                                else if (l_reg != q_reg)
                                begin
                                    l_reg <= l_reg + 3'd1;
                                    m_reg <= 3'd0;
                                end
                                else
                                begin
                                    q_reg <= q_reg + 3'd1;
                                    l_reg <= 3'd0;
                                    m_reg <= 3'd0;
                                end
                                state_reg <= S_COEF;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall      = state_reg != S_IDLE;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign coefficient   = coef_reg;
    assign power_x       = px_reg;
    assign power_y       = py_reg;
    assign power_z       = pz_reg;
    assign saturated     = sat_reg;
    assign zero_distance = zero_out_reg;
    assign last_of_run   = last_reg;

`ifndef NO_ASSERTIONS
    a_mul_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < STORE_DEPTH))
        else $error("store write beyond depth");

    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_distance) |-> (last_of_run && !saturated && coefficient == 0))
        else $error("zero-distance word malformed");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_MWAIT))
        else $error("multiplier result with no consumer");
`endif

endmodule
`default_nettype wire

FILE: rtl/dtc_ram.sv
`default_nettype none
module dtc_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 56
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

FILE: rtl/dtc_mul.sv
`default_nettype none
// signed multiply, round to nearest (ties away), clip to store range.
// four 28x28 partial products, one per cycle, then a rounding step.
module dtc_mul (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dtc_pkg::mul_req_t req,
    output dtc_pkg::mul_rsp_t      rsp
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_ACC,
        M_FIN
    } mstate_t;

    mstate_t          state_reg;
    logic [1:0]       cnt_reg;
    logic             neg_reg;
    logic [55:0]      ma_reg;
    logic [55:0]      mb_reg;
    logic [111:0]     prod_reg;
    dtc_pkg::shsel_t  sh_reg;
    logic             done_reg;
    logic signed [47:0] value_reg;
    logic             clip_reg;

    logic [27:0]  ah;
    logic [27:0]  bh;
    logic [55:0]  pp;
    logic [111:0] pp_sh;
    logic [111:0] rnd;
    logic         clip_c;
    logic [46:0]  mag;

    always_comb
    begin
        ah = cnt_reg[1] ? ma_reg[55:28] : ma_reg[27:0];
        bh = cnt_reg[0] ? mb_reg[55:28] : mb_reg[27:0];
        pp = 56'(ah) * 56'(bh);
        case (2'(cnt_reg[1]) + 2'(cnt_reg[0]))
            2'd0:    pp_sh = 112'(pp);
            2'd1:    pp_sh = 112'(pp) << 28;
            default: pp_sh = 112'(pp) << 56;
        endcase
    end

    always_comb
    begin
        case (sh_reg)
            dtc_pkg::SH_16: rnd = (prod_reg + (112'd1 << 15)) >> 16;
            dtc_pkg::SH_31: rnd = (prod_reg + (112'd1 << 30)) >> 31;
            default:        rnd = (prod_reg + (112'd1 << 31)) >> 32;
        endcase
        clip_c = rnd > 112'(dtc_pkg::STORE_LIM);
        mag    = clip_c ? dtc_pkg::STORE_LIM[46:0] : rnd[46:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg   <= req.a[55] ^ req.b[55];
                        ma_reg    <= req.a[55] ? 56'(-req.a) : 56'(req.a);
                        mb_reg    <= req.b[55] ? 56'(-req.b) : 56'(req.b);
                        sh_reg    <= req.sh;
                        prod_reg  <= '0;
                        cnt_reg   <= 2'd0;
                        state_reg <= M_ACC;
                    end
                end
                M_ACC:
                begin
                    prod_reg <= prod_reg + pp_sh;
                    cnt_reg  <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= M_FIN;
                    end
                end
                M_FIN:
                begin
                    value_reg <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                    clip_reg  <= clip_c;
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy  = state_reg != M_IDLE;
    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;
    assign rsp.clip  = clip_reg;

endmodule
`default_nettype wire
